>>> rtl/gcbls_pkg.sv
// Shared types and constants for the cut-grid binning block.
// No dependencies; imported by the top level, controller, datapath and checker.
package gcbls_pkg;

    localparam int MAX_CUTS_DEF   = 15;
    localparam int COUNT_BITS_DEF = 16;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 104;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_Y = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_LOAD_X = 3'd1,
        CMD_LOAD_Y = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_REPORT = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DIV_AVG,
        ST_DIV_RATIO,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic sweep_start;
        logic sweep_step;
        logic load_x;
        logic load_y;
        logic take_item;
        logic locate;
        logic rd_cell;
        logic wr_cell;
        logic scan_start;
        logic scan_step;
        logic mul;
        logic div_avg;
        logic avg_store;
        logic div_ratio;
        logic ratio_store;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_last;
        logic div_done;
        logic sum_zero;
        logic out_busy;
    } ctrl_sts_t;

endpackage

>>> rtl/grid_cut_binning_load_stats_top.sv
// Channel  | dir | handshake         | payload
// s_       | in  | s_tvalid/tready   | s_tuser cmd, s_tdata cut index/value, centroid
// m_       | out | m_tvalid/tready   | m_tdata statistics, m_tuser empty flag
// cfg_     | in  | cfg_valid/ready   | cfg_index register, cfg_data value
// One item at a time. Load is taken in the idle state. Add: locate, RAM read, write.
// Clear: all (MAX_CUTS+1)^2 counters, one counter per cycle through the RAM write port;
// the same sweep runs after reset, no items taken meanwhile.
// Report: cell scan, then the average divide and, unless the sum is zero, the ratio divide.
// A result waiting on m_tready stalls only the next report at its output step.
// Depends on gcbls_pkg, gcbls_ctrl, gcbls_dp.
module grid_cut_binning_load_stats_top import gcbls_pkg::*; #(
    parameter int MAX_CUTS   = MAX_CUTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] cut_index, [35:4] cut_value, [67:36] centroid_x, [99:68] centroid_y
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] cmd
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] max_count, [19:16] max_col, [23:20] max_row, [39:24] total_faces,
    // [71:40] average_q16, [96:72] ratio_q16
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] empty_flag
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    gcbls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcbls_dp #(
        .MAX_CUTS   (MAX_CUTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

>>> rtl/gcbls_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module gcbls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/gcbls_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
module gcbls_div #(
    parameter int DW = 41,
    parameter int VW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quot,
    output logic          done
);
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   quot_reg, quot_next;
    logic [VW:0]     rem_reg, rem_next;
    logic [VW-1:0]   dvs_reg, dvs_next;
    logic [VW:0]     rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[VW-1:0], quot_reg[DW-1]};
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNTW'(DW);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next  = rem_sh - {1'b0, dvs_reg};
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;
endmodule

>>> rtl/gcbls_ctrl.sv
// Controller state machine: sequences add, clear sweep, report scan and divides.
// Depends on gcbls_pkg.
module gcbls_ctrl import gcbls_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [CMD_W-1:0] s_tuser,
    output logic             s_tready,
    input  ctrl_sts_t        sts,
    output ctrl_cmd_t        cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        CMD_CLEAR: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        CMD_LOAD_X: cmd.load_x = 1'b1;
                        CMD_LOAD_Y: cmd.load_y = 1'b1;
                        CMD_ADD: begin
                            cmd.take_item = 1'b1;
                            state_next    = ST_LOCATE;
                        end
                        CMD_REPORT: begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOCATE: begin
                cmd.locate = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_cell = 1'b1;
                state_next  = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.wr_cell = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL: begin
                cmd.mul     = 1'b1;
                cmd.div_avg = 1'b1;
                state_next  = ST_DIV_AVG;
            end
            ST_DIV_AVG: begin
                if (sts.div_done) begin
                    cmd.avg_store = 1'b1;
                    if (sts.sum_zero) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.div_ratio = 1'b1;
                        state_next    = ST_DIV_RATIO;
                    end
                end
            end
            ST_DIV_RATIO: begin
                if (sts.div_done) begin
                    cmd.ratio_store = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/gcbls_dp.sv
// Datapath: cut registers, cell locate, counter RAM, scan statistics, divides.
// Depends on gcbls_pkg, gcbls_ram and gcbls_div.
module gcbls_dp import gcbls_pkg::*; #(
    parameter int MAX_CUTS   = MAX_CUTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts
);
    localparam int GRID_SIDE = MAX_CUTS + 1;
    localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(GRID_SIDE);
    localparam int SUM_W     = COUNT_BITS + 8;
    localparam int PW        = COUNT_BITS + 9;
    localparam int DW        = PW + 16;

    // input fields
    logic        [3:0]  in_idx;
    logic signed [31:0] in_val, in_x, in_y;
    assign in_idx = s_tdata[3:0];
    assign in_val = s_tdata[35:4];
    assign in_x   = s_tdata[67:36];
    assign in_y   = s_tdata[99:68];

    // configuration
    logic [3:0] num_x_reg, num_y_reg, cfg_clamped;
    assign cfg_clamped = (32'(cfg_data) > MAX_CUTS) ? 4'(MAX_CUTS) : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_x_reg <= '0;
            num_y_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_NUM_X) begin
                num_x_reg <= cfg_clamped;
            end else if (cfg_index == CFG_NUM_Y) begin
                num_y_reg <= cfg_clamped;
            end
        end
    end

    // cut stores
    logic signed [31:0] cut_x_reg [MAX_CUTS];
    logic signed [31:0] cut_y_reg [MAX_CUTS];

    always_ff @(posedge aclk) begin
        for (int e = 0; e < MAX_CUTS; e++) begin
            if (cmd.load_x && 32'(in_idx) == e) begin
                cut_x_reg[e] <= in_val;
            end
            if (cmd.load_y && 32'(in_idx) == e) begin
                cut_y_reg[e] <= in_val;
            end
        end
    end

    // add path: capture, locate, read, write back
    logic signed [31:0] cx_reg, cy_reg;
    logic [CW-1:0]      col_reg, row_reg, col_next, row_next;
    logic [AW-1:0]      add_addr, cell_addr_reg;

    always_comb begin
        col_next = '0;
        row_next = '0;
        for (int i = 0; i < MAX_CUTS; i++) begin
            if (i < 32'(num_x_reg) && cx_reg >= cut_x_reg[i]) begin
                col_next = CW'(i + 1);
            end
            if (i < 32'(num_y_reg) && cy_reg >= cut_y_reg[i]) begin
                row_next = CW'(i + 1);
            end
        end
    end

    assign add_addr = AW'(32'(col_reg) * GRID_SIDE + 32'(row_reg));

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            cx_reg <= in_x;
            cy_reg <= in_y;
        end
        if (cmd.locate) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.rd_cell) begin
            cell_addr_reg <= add_addr;
        end
    end

    // counter RAM
    logic [AW-1:0]         sweep_addr_reg, scan_addr, ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_inc;
    logic                  ram_we, ram_re;

    assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_we    = cmd.wr_cell | cmd.sweep_step;
    assign ram_waddr = cmd.sweep_step ? sweep_addr_reg : cell_addr_reg;
    assign ram_wdata = cmd.sweep_step ? '0 : cnt_inc;
    assign ram_re    = cmd.rd_cell | cmd.scan_step;
    assign ram_raddr = cmd.scan_step ? scan_addr : add_addr;

    gcbls_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
        end else if (cmd.sweep_start) begin
            sweep_addr_reg <= '0;
        end else if (cmd.sweep_step) begin
            sweep_addr_reg <= sweep_addr_reg + 1'b1;
        end
    end

    // report scan, column outer and row inner; read data arrives in the cycle after its address
    logic [3:0]            si_reg, sj_reg, di_reg, dj_reg, mc_reg, mr_reg;
    logic                  pend_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_BITS-1:0] max_reg;
    logic [8:0]            cells_reg;
    logic [PW-1:0]         prod_reg;

    assign scan_addr = AW'(32'(si_reg) * GRID_SIDE + 32'(sj_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.scan_step;
        end
        if (cmd.scan_start) begin
            si_reg    <= '0;
            sj_reg    <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            mc_reg    <= '0;
            mr_reg    <= '0;
            cells_reg <= (9'(num_x_reg) + 9'd1) * (9'(num_y_reg) + 9'd1);
        end else begin
            if (cmd.scan_step) begin
                di_reg <= si_reg;
                dj_reg <= sj_reg;
                if (sj_reg == num_y_reg) begin
                    sj_reg <= '0;
                    si_reg <= si_reg + 1'b1;
                end else begin
                    sj_reg <= sj_reg + 1'b1;
                end
            end
            if (pend_reg) begin
                sum_reg <= sum_reg + SUM_W'(ram_rdata);
                if (ram_rdata > max_reg) begin
                    max_reg <= ram_rdata;
                    mc_reg  <= di_reg;
                    mr_reg  <= dj_reg;
                end
            end
        end
        if (cmd.mul) begin
            prod_reg <= PW'(max_reg) * PW'(cells_reg);
        end
    end

    // shared divider for average and ratio
    logic [DW-1:0] div_dividend, div_quot;
    logic [SUM_W-1:0] div_divisor;
    logic          div_done;
    logic [31:0]   avg_reg;
    logic [24:0]   ratio_reg;

    assign div_dividend = cmd.div_avg ? (DW'(sum_reg) << 16) : (DW'(prod_reg) << 16);
    assign div_divisor  = cmd.div_avg ? SUM_W'(cells_reg) : sum_reg;

    gcbls_div #(
        .DW (DW),
        .VW (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_avg | cmd.div_ratio),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.avg_store) begin
            avg_reg <= (|div_quot[DW-1:32]) ? '1 : div_quot[31:0];
        end
        if (cmd.mul) begin
            ratio_reg <= '0;
        end else if (cmd.ratio_store) begin
            ratio_reg <= (|div_quot[DW-1:25]) ? '1 : div_quot[24:0];
        end
    end

    // result register
    logic [63:0] max_w, sum_w;
    logic [15:0] total16;
    logic        m_tvalid_reg;

    assign max_w   = 64'(max_reg);
    assign sum_w   = 64'(sum_reg);
    assign total16 = (sum_w > 64'hFFFF) ? 16'hFFFF : sum_w[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata <= {7'b0, ratio_reg, avg_reg, total16, mr_reg, mc_reg, max_w[15:0]};
            m_tuser <= (sum_reg == '0);
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign sts.sweep_last = (sweep_addr_reg == AW'(DEPTH - 1));
    assign sts.scan_last  = (si_reg == num_x_reg) && (sj_reg == num_y_reg);
    assign sts.div_done   = div_done;
    assign sts.sum_zero   = (sum_reg == '0);
    assign sts.out_busy   = m_tvalid_reg && !m_tready;
endmodule

>>> rtl/gcbls_checker.sv
// Port-level checks for the binning block, bound to the top level.
// Depends on gcbls_pkg.
module gcbls_checker import gcbls_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [CMD_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);
    a_reset_no_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    a_add_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_ADD |=> !s_tready)
        else $error("item taken while add in progress");

    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[39:24] == 16'd0)))
        else $error("empty flag disagrees with total");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[96:72] == 25'd0 && m_tdata[15:0] == 16'd0)
        else $error("empty grid with nonzero max or ratio");
endmodule

bind grid_cut_binning_load_stats_top gcbls_checker u_gcbls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/testbench.sv
// Self-checking testbench for grid_cut_binning_load_stats_top.
// A scoreboard class predicts the report statistics from the accepted commands.
// Depends on gcbls_pkg and the block's RTL.
module testbench;
    import gcbls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCUTS = 15;
    localparam int SIDE  = 16;
    localparam int SETTLE = 400;      // covers clear sweep and a full report
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [15:0] max_count;
        logic [3:0]  max_col;
        logic [3:0]  max_row;
        logic [15:0] total;
        logic [31:0] average;
        logic [24:0] ratio;
        logic        empty;
    } grid_stats_t;

    class grid_stats_board;
        logic [31:0] x_cut [NCUTS];
        logic [31:0] y_cut [NCUTS];
        int unsigned cell_count [SIDE*SIDE];
        int unsigned num_x, num_y;
        grid_stats_t pending [$];
        int errors;

        function new();
            num_x = 0;
            num_y = 0;
            errors = 0;
            foreach (cell_count[i]) cell_count[i] = 0;
            foreach (x_cut[i]) begin
                x_cut[i] = '0;
                y_cut[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            int unsigned n;
            n = (val > NCUTS) ? NCUTS : val;
            if (idx == CFG_NUM_X) num_x = n;
            else if (idx == CFG_NUM_Y) num_y = n;
        endfunction

        function int unsigned find_bin(logic [31:0] v, bit is_x);
            int unsigned pos, n;
            logic [31:0] c;
            pos = 0;
            n = is_x ? num_x : num_y;
            for (int i = 0; i < n; i++) begin
                c = is_x ? x_cut[i] : y_cut[i];
                if ($signed(v) >= $signed(c)) pos = i + 1;
            end
            return pos;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [S_TDATA_W-1:0] d);
            logic [3:0]  idx;
            logic [31:0] cval, cx, cy;
            int unsigned bin_idx;
            longint unsigned mx, sum, cells, avg, rat;
            grid_stats_t r;
            idx  = d[3:0];
            cval = d[35:4];
            cx   = d[67:36];
            cy   = d[99:68];
            case (cmd)
                CMD_CLEAR: foreach (cell_count[i]) cell_count[i] = 0;
                CMD_LOAD_X: if (idx < NCUTS) x_cut[idx] = cval;
                CMD_LOAD_Y: if (idx < NCUTS) y_cut[idx] = cval;
                CMD_ADD: begin
                    bin_idx = find_bin(cx, 1) * SIDE + find_bin(cy, 0);
                    if (cell_count[bin_idx] < 65535) cell_count[bin_idx]++;
                end
                CMD_REPORT: begin
                    mx = 0;
                    sum = 0;
                    rat = 0;
                    r.max_col = 0;
                    r.max_row = 0;
                    // column outer, row inner; first strict maximum wins
                    for (int i = 0; i <= num_x; i++)
                        for (int j = 0; j <= num_y; j++) begin
                            if (cell_count[i*SIDE+j] > mx) begin
                                mx = cell_count[i*SIDE+j];
                                r.max_col = 4'(i);
                                r.max_row = 4'(j);
                            end
                            sum += cell_count[i*SIDE+j];
                        end
                    cells = (num_x + 1) * (num_y + 1);
                    avg = (sum << 16) / cells;
                    if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
                    if (sum != 0) begin
                        rat = ((mx * cells) << 16) / sum;
                        if (rat > 64'h1FF_FFFF) rat = 64'h1FF_FFFF;
                    end
                    r.max_count = mx[15:0];
                    r.total     = (sum > 65535) ? 16'hFFFF : sum[15:0];
                    r.average   = avg[31:0];
                    r.ratio     = rat[24:0];
                    r.empty     = (sum == 0);
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] d, logic u);
            grid_stats_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected report transaction, tdata %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("max_count", e.max_count, d[15:0]);
            cmp("max_col",   e.max_col,   d[19:16]);
            cmp("max_row",   e.max_row,   d[23:20]);
            cmp("total",     e.total,     d[39:24]);
            cmp("average",   e.average,   d[71:40]);
            cmp("ratio",     e.ratio,     d[96:72]);
            cmp("empty",     e.empty,     u);
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    grid_stats_board sb = new();
    int  burst_left = 0;
    bit  long_hold = 0;
    bit  rx_choppy = 1;
    int  idle_cycles = 0;

    always #5 aclk = ~aclk;

    grid_cut_binning_load_stats_top u_top (.*);

    // receiver: random stalls, occasionally a long hold-off
    always @(negedge aclk) begin
        if (long_hold) begin
            m_tready <= 1'b0;
            repeat (2000) @(negedge aclk);
            long_hold = 0;
        end else begin
            m_tready <= rx_choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [3:0] idx,
                        input logic [31:0] cval, input logic [31:0] cx, input logic [31:0] cy);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, cy, cx, cval, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_results();
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    // every expected report is out and the block has settled
    task automatic drain();
        idle_sender();
        wait_results();
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned nx, input int unsigned ny);
        drain();
        write_reg(CFG_NUM_X, CFG_DAT_W'(nx));
        write_reg(CFG_NUM_Y, CFG_DAT_W'(ny));
    endtask

    function automatic logic [31:0] pick_coord(bit is_x);
        logic [31:0] c;
        c = is_x ? sb.x_cut[$urandom_range(0, NCUTS-1)] : sb.y_cut[$urandom_range(0, NCUTS-1)];
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return c;
            2:       return c - 1;
            default: return c + $urandom_range(0, 5) - 2;
        endcase
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            send($urandom_range(1, 2) == 1 ? CMD_LOAD_X : CMD_LOAD_Y,
                 4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom());
        else if (sel < 82)
            send(CMD_ADD, 4'($urandom()), $urandom(), pick_coord(1), pick_coord(0));
        else if (sel < 92)
            send(CMD_REPORT, 4'($urandom()), $urandom(), $urandom(), $urandom());
        else if (sel < 95)
            send(CMD_CLEAR, 4'($urandom()), $urandom(), $urandom(), $urandom());
        else
            send(CMD_W'($urandom_range(5, 7)), 4'($urandom()), $urandom(), $urandom(),
                 $urandom());
    endtask

    initial begin
        logic [31:0] v;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        set_grid(15, 15);

        // cut tables: every slot written before any centroid is binned
        for (int i = 0; i < NCUTS; i++) begin
            v = (i == 0) ? 32'h8000_0000 : (i == NCUTS-1) ? 32'h7FFF_FFFF : (i - 7) * 32'h0010_0000;
            send(CMD_LOAD_X, 4'(i), v, '0, '0);
            send(CMD_LOAD_Y, 4'(i), -v, '0, '0);
        end
        send(CMD_LOAD_X, 4'd15, 32'h1234_5678, '0, '0);   // out of range slot, ignored
        send(CMD_ADD, '0, '0, 32'h8000_0000, 32'h8000_0000);
        send(CMD_ADD, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_ADD, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_ADD, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF);
        send(CMD_ADD, '0, '0, 32'h0010_0000, 32'hFFF0_0000);
        send(CMD_ADD, '0, '0, 32'h000F_FFFF, 32'hFFEF_FFFF);
        for (int c = 5; c <= 7; c++) send(CMD_W'(c), 4'hF, '1, '1, '1);
        send(CMD_REPORT, '0, '0, '0, '0);
        send(CMD_CLEAR, '0, '0, '0, '0);
        send(CMD_REPORT, '0, '0, '0, '0);

        // single-cell grid: every centroid lands in the same counter
        set_grid(0, 0);
        rx_choppy = 0;
        for (int n = 0; n < 40; n++) send(CMD_ADD, '0, '0, $urandom(), $urandom());
        send(CMD_REPORT, '0, '0, '0, '0);
        set_grid(1, 0);
        send(CMD_REPORT, '0, '0, '0, '0);
        send(CMD_CLEAR, '0, '0, '0, '0);
        rx_choppy = 1;

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_grid(0, 15);
                1:       set_grid(15, 0);
                2:       set_grid(15, 15);
                3:       set_grid(0, 0);
                default: set_grid($urandom_range(0, 15), $urandom_range(0, 15));
            endcase
            rx_choppy = (ph != 4);
            if (ph == 5) begin
                long_hold = 1;
                for (int k = 0; k < 6; k++) begin
                    repeat (3) random_item();
                    send(CMD_REPORT, '0, '0, '0, '0);
                end
            end
            repeat (160) random_item();
            send(CMD_REPORT, '0, '0, '0, '0);
        end

        idle_sender();
        wait_results();
        repeat (SETTLE) @(negedge aclk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
